FILE: rtl/linear_probe_hash_table_top_defines.svh
// Assertion helpers for the hash table RTL.
// Both expect clk_i and rst_ni in the scope of use.
`ifndef LINEAR_PROBE_HASH_TABLE_TOP_DEFINES_SVH
`define LINEAR_PROBE_HASH_TABLE_TOP_DEFINES_SVH

// Same-cycle implication.
`define LPHT_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LPHT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/lpht_pkg.sv
`timescale 1ns / 1ps
package lpht_pkg;

  localparam int KeyW = 31;
  localparam int ValW = 32;
  localparam int OccW = 5;
  localparam int CmdW = 2;
  localparam int StatW = 2;

  // Depth of the queue between front and back.
  localparam int QDepth = 2;

  localparam logic [CmdW-1:0] CmdInsert = 2'd0;
  localparam logic [CmdW-1:0] CmdSearch = 2'd1;
  localparam logic [CmdW-1:0] CmdDelete = 2'd2;

  localparam logic [StatW-1:0] StatEmpty = 2'd0;
  localparam logic [StatW-1:0] StatLive  = 2'd1;
  localparam logic [StatW-1:0] StatDel   = 2'd2;

  typedef struct packed {
    logic [CmdW-1:0]        cmd;
    logic [KeyW-1:0]        key;
    logic signed [ValW-1:0] value;
  } req_t;

endpackage

FILE: rtl/lpht_req_if.sv
`timescale 1ns / 1ps
interface lpht_req_if;
  import lpht_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [CmdW-1:0]        cmd;
  logic [KeyW-1:0]        key;
  logic signed [ValW-1:0] value;

  modport source (output valid, cmd, key, value, input ready);
  modport sink (input valid, cmd, key, value, output ready);
endinterface

FILE: rtl/lpht_rsp_if.sv
`timescale 1ns / 1ps
interface lpht_rsp_if;
  import lpht_pkg::*;

  logic                   valid;
  logic                   ready;
  logic                   found;
  logic signed [ValW-1:0] data_out;
  logic                   full_res;
  logic [OccW-1:0]        occupancy;

  modport source (output valid, found, data_out, full_res, occupancy, input ready);
  modport sink (input valid, found, data_out, full_res, occupancy, output ready);
endinterface

FILE: rtl/lpht_ram.sv
`timescale 1ns / 1ps
module lpht_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/lpht_queue.sv
`timescale 1ns / 1ps
module lpht_queue #(
  parameter int Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [Width-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [Width-1:0] pop_data_o
);
  import lpht_pkg::*;

  localparam int PtrW = $clog2(QDepth);
  localparam int CntW = $clog2(QDepth + 1);

  logic [Width-1:0] mem_q [QDepth];
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             push, pop;

  assign push_ready_o = cnt_q != CntW'(QDepth);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_data_o   = mem_q[rd_q];
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_d  = push ? wr_q + 1'b1 : wr_q;
    rd_d  = pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

FILE: rtl/lpht_front.sv
`timescale 1ns / 1ps
module lpht_front #(
  parameter int SLOTS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  lpht_req_if.sink                 req_i,
  input  logic                     clear_busy_i,
  output logic                     push_valid_o,
  input  logic                     push_ready_i,
  output lpht_pkg::req_t           push_req_o,
  output logic [$clog2(SLOTS)-1:0] push_home_o
);
  import lpht_pkg::*;

  localparam int AddrW  = $clog2(SLOTS);
  localparam int RecipW = KeyW + 1;
  localparam int ProdW  = KeyW + RecipW;
  // Reciprocal of SLOTS scaled by 2^(KeyW + AddrW), rounded up; the product
  // shifted down by KeyW + AddrW is the exact quotient for every key.
  localparam logic [RecipW-1:0] Recip =
    RecipW'(((64'd1 << (KeyW + AddrW)) + 64'(SLOTS) - 64'd1) / 64'(SLOTS));
  localparam logic [AddrW-1:0] SlotsLo = AddrW'(SLOTS);

  req_t             req_q;
  logic [ProdW-1:0] prod;
  logic [AddrW-1:0] quot_q;
  logic             run_q, hold_q;
  logic             accept;

  assign req_i.ready  = !run_q && !hold_q && !clear_busy_i;
  assign accept       = req_i.valid && req_i.ready;
  assign push_valid_o = hold_q;
  assign push_req_o   = req_q;

  assign prod = {{RecipW{1'b0}}, req_q.key} * {{KeyW{1'b0}}, Recip};

  // The remainder is below 2^AddrW, so key - quotient * SLOTS needs only its low bits.
  assign push_home_o = req_q.key[AddrW-1:0] - quot_q * SlotsLo;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      hold_q <= 1'b0;
    end else begin
      if (accept) begin
        run_q <= 1'b1;
      end else if (run_q) begin
        run_q  <= 1'b0;
        hold_q <= 1'b1;
      end else if (hold_q && push_ready_i) begin
        hold_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q.cmd   <= req_i.cmd;
      req_q.key   <= req_i.key;
      req_q.value <= req_i.value;
    end
    if (run_q) begin
      quot_q <= prod[KeyW + AddrW +: AddrW];
    end
  end

endmodule

FILE: rtl/lpht_back.sv
`timescale 1ns / 1ps
`include "linear_probe_hash_table_top_defines.svh"
module lpht_back #(
  parameter int SLOTS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     pop_valid_i,
  output logic                     pop_ready_o,
  input  lpht_pkg::req_t           pop_req_i,
  input  logic [$clog2(SLOTS)-1:0] pop_home_i,
  output logic                     clear_busy_o,
  lpht_rsp_if.source               rsp_o
);
  import lpht_pkg::*;

  localparam int AddrW = $clog2(SLOTS);
  localparam int CntW  = $clog2(SLOTS + 1);
  localparam int KvW   = KeyW + ValW;
  localparam logic [AddrW-1:0] LastIdx = AddrW'(SLOTS - 1);

  localparam logic [1:0] SClear = 2'd0;
  localparam logic [1:0] SIdle  = 2'd1;
  localparam logic [1:0] SProbe = 2'd2;

  logic [1:0]             state_q, state_d;
  logic [AddrW-1:0]       idx_q, idx_d, n_q, n_d, clr_q, clr_d, nxt_idx;
  logic [CmdW-1:0]        cmd_q;
  logic [KeyW-1:0]        key_q;
  logic signed [ValW-1:0] value_q;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic [CntW+OccW-1:0]   cnt_ext;

  logic                   out_valid_q, out_valid_d;
  logic                   found_q, found_d, full_q, full_d;
  logic signed [ValW-1:0] data_q, data_d;
  logic [OccW-1:0]        occ_q, occ_d;
  logic                   out_load, pop;

  logic [AddrW-1:0]       raddr, waddr;
  logic                   stat_we, kv_we;
  logic [StatW-1:0]       stat_wdata, stat_rdata;
  logic [KvW-1:0]         kv_rdata;
  logic [KeyW-1:0]        rd_key;
  logic signed [ValW-1:0] rd_val;
  logic                   live, kmatch, last;

  lpht_ram #(.Width(StatW), .Depth(SLOTS)) u_stat_ram (
    .clk_i   (clk_i),
    .we_i    (stat_we),
    .waddr_i (waddr),
    .wdata_i (stat_wdata),
    .raddr_i (raddr),
    .rdata_o (stat_rdata)
  );

  lpht_ram #(.Width(KvW), .Depth(SLOTS)) u_kv_ram (
    .clk_i   (clk_i),
    .we_i    (kv_we),
    .waddr_i (waddr),
    .wdata_i ({key_q, value_q}),
    .raddr_i (raddr),
    .rdata_o (kv_rdata)
  );

  assign rd_key  = kv_rdata[ValW +: KeyW];
  assign rd_val  = kv_rdata[ValW-1:0];
  assign live    = stat_rdata == StatLive;
  assign kmatch  = live && (rd_key == key_q);
  assign last    = n_q == LastIdx;
  assign nxt_idx = (idx_q == LastIdx) ? '0 : idx_q + 1'b1;

  assign clear_busy_o = state_q == SClear;
  assign pop_ready_o  = (state_q == SIdle) && (!out_valid_q || rsp_o.ready);
  assign pop          = pop_valid_i && pop_ready_o;
  assign cnt_ext      = {{OccW{1'b0}}, cnt_d};

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    n_d        = n_q;
    clr_d      = clr_q;
    cnt_d      = cnt_q;
    raddr      = nxt_idx;
    waddr      = idx_q;
    stat_we    = 1'b0;
    kv_we      = 1'b0;
    stat_wdata = StatLive;
    out_load   = 1'b0;
    found_d    = 1'b0;
    data_d     = '0;
    full_d     = 1'b0;

    unique case (state_q)
      SClear: begin
        stat_we    = 1'b1;
        waddr      = clr_q;
        stat_wdata = StatEmpty;
        clr_d      = clr_q + 1'b1;
        if (clr_q == LastIdx) begin
          state_d = SIdle;
        end
      end
      SIdle: begin
        raddr = pop_home_i;
        idx_d = pop_home_i;
        n_d   = '0;
        if (pop) begin
          case (pop_req_i.cmd) inside
            CmdInsert, CmdSearch, CmdDelete: state_d = SProbe;
            default:                         out_load = 1'b1;
          endcase
        end
      end
      SProbe: begin
        if (cmd_q == CmdInsert) begin
          if (!live || kmatch) begin
            kv_we    = 1'b1;
            stat_we  = 1'b1;
            found_d  = live;
            cnt_d    = live ? cnt_q : cnt_q + 1'b1;
            out_load = 1'b1;
          end else if (last) begin
            full_d   = 1'b1;
            out_load = 1'b1;
          end
        end else begin
          if (stat_rdata == StatEmpty) begin
            out_load = 1'b1;
          end else if (kmatch) begin
            found_d  = 1'b1;
            data_d   = rd_val;
            out_load = 1'b1;
            if (cmd_q == CmdDelete) begin
              stat_we    = 1'b1;
              stat_wdata = StatDel;
              cnt_d      = cnt_q - 1'b1;
            end
          end else if (last) begin
            out_load = 1'b1;
          end
        end
        if (out_load) begin
          state_d = SIdle;
        end else begin
          idx_d = nxt_idx;
          n_d   = n_q + 1'b1;
        end
      end
      default: state_d = SIdle;
    endcase

    occ_d       = cnt_ext[OccW-1:0];
    out_valid_d = out_load ? 1'b1 : (out_valid_q && !rsp_o.ready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SClear;
      clr_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    n_q   <= n_d;
    if (pop) begin
      cmd_q   <= pop_req_i.cmd;
      key_q   <= pop_req_i.key;
      value_q <= pop_req_i.value;
    end
    if (out_load) begin
      found_q <= found_d;
      data_q  <= data_d;
      full_q  <= full_d;
      occ_q   <= occ_d;
    end
  end

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.found     = found_q;
  assign rsp_o.data_out  = data_q;
  assign rsp_o.full_res  = full_q;
  assign rsp_o.occupancy = occ_q;

  `LPHT_ASSERT(a_cnt_bound, 1'b1, cnt_q <= CntW'(SLOTS), "live count exceeds slot count")
  `LPHT_ASSERT(a_load_free, out_load, !out_valid_q || rsp_o.ready, "result register overrun")
  `LPHT_ASSERT(a_no_pop_clear, state_q == SClear, !pop_ready_o, "queue popped during clear")
  `LPHT_ASSERT_NEXT(a_probe_step, (state_q == SProbe) && !out_load, (state_q == SProbe) && (n_q == AddrW'($past(n_q) + 1'b1)), "probe counter did not advance")

endmodule

FILE: rtl/linear_probe_hash_table_top.sv
`timescale 1ns / 1ps
// Open-addressing hash table with linear probing, SLOTS entries of a 31-bit
// key and a 32-bit value. Each item is an insert, search or delete; each item
// produces exactly one result item with found, data_out, full_res and the
// occupancy after the command. After reset the block sweeps the slot status
// memory, marking every slot empty, and holds req_i.ready low meanwhile. The
// front multiplies the key by a reciprocal of SLOTS to find the home slot,
// then hands the command to a two-entry queue, and takes the next item only
// once the queue has taken the last one, so it can take a new item while the
// back still probes the previous one. The back pops a command, which also
// issues the home slot read, then probes one slot per cycle, from one to
// SLOTS slots, since every probe is one read of the table memory through
// its single registered read port. The back pops nothing while its result
// register still waits, so a stalled receiver fills the queue and then
// stalls the input. Unused command code three changes nothing and returns
// the current occupancy.
module linear_probe_hash_table_top #(
  parameter int SLOTS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lpht_req_if.sink    req_i,
  lpht_rsp_if.source  rsp_o
);
  import lpht_pkg::*;

  localparam int AddrW  = $clog2(SLOTS);
  localparam int EntryW = $bits(req_t) + AddrW;

  // Front to queue.
  logic             push_valid, push_ready;
  req_t             push_req;
  logic [AddrW-1:0] push_home;

  // Queue to back.
  logic              pop_valid, pop_ready;
  logic [EntryW-1:0] pop_data;
  req_t              pop_req;
  logic [AddrW-1:0]  pop_home;

  logic clear_busy;

  // Reduce the key to its home slot and hand the command on.
  lpht_front #(.SLOTS(SLOTS)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_i),
    .clear_busy_i (clear_busy),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_req_o   (push_req),
    .push_home_o  (push_home)
  );

  // Decouple the front from the probing back end.
  lpht_queue #(.Width(EntryW)) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  ({push_req, push_home}),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  assign pop_req  = pop_data[EntryW-1:AddrW];
  assign pop_home = pop_data[AddrW-1:0];

  // Probe the table, update it and hold the result until taken.
  lpht_back #(.SLOTS(SLOTS)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pop_valid_i  (pop_valid),
    .pop_ready_o  (pop_ready),
    .pop_req_i    (pop_req),
    .pop_home_i   (pop_home),
    .clear_busy_o (clear_busy),
    .rsp_o        (rsp_o)
  );

endmodule
